// ===== rtl/mmt_pkg.sv =====
// Shared types and constants for the modulation mixer table.
// Holds the request/result payloads, the table entry layout and the command codes.
// No dependencies.
package mmt_pkg;

    localparam int ENTRIES = 128;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Table size as a 9-bit value for the index range check.
    localparam logic [8:0] ENTRIES_W = 9'(ENTRIES);

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_LINEAR = 3'd1;
    localparam logic [2:0] CMD_INVERT = 3'd2;
    localparam logic [2:0] CMD_LOG    = 3'd3;
    localparam logic [2:0] CMD_PITCH  = 3'd4;
    localparam logic [2:0] CMD_NOTE   = 3'd5;

    localparam logic [2:0] FLD_BASE = 3'd0;
    localparam logic [2:0] FLD_LFO  = 3'd1;
    localparam logic [2:0] FLD_ADSR = 3'd2;
    localparam logic [2:0] FLD_AD   = 3'd3;
    localparam logic [2:0] FLD_NOTE = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  index;
        logic [2:0]  field;
        logic [15:0] data;
        logic [15:0] lfo_level;
        logic [15:0] adsr_level;
        logic [15:0] ad_level;
        logic        force_update;
    } req_t;

    typedef struct packed {
        logic [15:0] level;
        logic        changed;
    } res_t;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] lfo_amt;
        logic [15:0] adsr_amt;
        logic [15:0] ad_amt;
        logic [15:0] note;
        logic [15:0] last;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } calc_ctl_t;

endpackage

// ===== rtl/modulation_mixer_table.sv =====
// Modulation mixer table, top level.
// Instantiates the parameter table memory and the mixing datapath, and
// holds the sequencer, the note voltage register and the result register.
//
// Usage: each request on the req channel (req_valid/req_ready, payload
// req) either writes one setting of a table entry, sets the shared note
// voltage, or mixes one entry in linear, inverted, log or pitch mode.
// Every request produces exactly one result on the res channel
// (res_valid/res_ready, payload res); writes, note voltage settings and
// unused codes give level zero with changed clear.
// Timing: a request is taken only while the sequencer is idle. The entry
// read at acceptance arrives in the multiply cycle, followed by a scaling
// cycle and a final cycle that writes the entry back and loads the result
// register; res_valid rises as that final cycle completes. A new request
// is taken only after the previous one has left its final cycle.
// Stalls: a waiting result does not block acceptance of the next request;
// that request holds in its final cycle until the result register frees.
// Reset: all table entries and the note voltage read as zero; valid bits
// clear at once, so no clearing pass is needed.
// Depends on mmt_pkg, mmt_table and mmt_calc.
module modulation_mixer_table
    import mmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    req_t        item_reg;
    logic [15:0] note_reg;
    logic        res_valid_reg, res_valid_next;
    res_t        res_reg, res_next;

    logic              accept;
    logic              finish;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              in_range;
    logic              is_proc;
    logic              is_write;
    entry_t            rd_data;
    entry_t            wb_entry;
    tbl_wr_t           wr;
    calc_ctl_t         ctl;
    logic [15:0]       calc_level;
    logic              calc_changed;
    logic [8:0]        req_idx_ext;
    logic [8:0]        item_idx_ext;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign finish    = (state_reg == S_FIN) && (!res_valid_reg || res_ready);

    assign req_idx_ext  = {2'b00, req.index};
    assign item_idx_ext = {2'b00, item_reg.index};
    assign rd_addr      = req_idx_ext[ADDR_W-1:0];
    assign wr_addr      = item_idx_ext[ADDR_W-1:0];
    assign in_range     = item_idx_ext < ENTRIES_W;

    assign is_proc  = in_range && ((item_reg.command == CMD_LINEAR)
                                || (item_reg.command == CMD_INVERT)
                                || (item_reg.command == CMD_LOG)
                                || (item_reg.command == CMD_PITCH));
    assign is_write = in_range && (item_reg.command == CMD_WRITE)
                      && (item_reg.field <= FLD_NOTE);

    assign ctl.mul_en = (state_reg == S_MUL);
    assign ctl.add_en = (state_reg == S_ADD);

    mmt_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    mmt_calc u_calc (
        .clk          (clk),
        .ctl          (ctl),
        .item         (item_reg),
        .ent          (rd_data),
        .note_voltage (note_reg),
        .level        (calc_level),
        .changed      (calc_changed)
    );

    // The table read data holds until the next read, so it is still the
    // addressed entry in the final cycle and serves as the write-back base.
    always_comb
    begin
        wb_entry = rd_data;
        if (item_reg.command == CMD_WRITE)
        begin
            unique case (item_reg.field)
                FLD_BASE: wb_entry.base     = item_reg.data;
                FLD_LFO:  wb_entry.lfo_amt  = item_reg.data;
                FLD_ADSR: wb_entry.adsr_amt = item_reg.data;
                FLD_AD:   wb_entry.ad_amt   = item_reg.data;
                FLD_NOTE: wb_entry.note     = item_reg.data;
                default:  wb_entry = rd_data;
            endcase
        end
        else
        begin
            wb_entry.last = calc_level;
        end
        wr.en   = finish && (is_proc || is_write);
        wr.addr = wr_addr;
        wr.data = wb_entry;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = S_FIN;
            S_FIN:  if (finish) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (finish)
        begin
            res_valid_next  = 1'b1;
            res_next.level   = is_proc ? calc_level : 16'h0000;
            res_next.changed = is_proc && calc_changed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            note_reg      <= 16'h0000;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (accept && (req.command == CMD_NOTE))
            begin
                note_reg <= req.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The table is written only as a request leaves its final cycle.
    a_wr_in_fin : assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_FIN) && (!res_valid_reg || res_ready))
        else $error("table write outside the final cycle");

    // An accepted request always starts the multiply cycle next.
    a_accept_seq : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MUL))
        else $error("accepted request did not enter the multiply cycle");

    // Finishing a request always leaves a result waiting.
    a_finish_res : assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> res_valid_reg)
        else $error("finished request did not produce a result");

    // Requests that do not mix report a zero level with changed clear.
    a_nonproc_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !is_proc) |=> (res_reg.level == 16'h0000) && !res_reg.changed)
        else $error("non-mixing request gave a nonzero result");

    // A result waiting on a stalled receiver is never overwritten.
    a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule

// ===== rtl/mmt_table.sv =====
// Parameter table storage: one synchronous memory with a registered read port.
// Per-entry valid bits make never-written entries read as all zero after reset.
// Depends on mmt_pkg.
module mmt_table
    import mmt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  tbl_wr_t           wr
);

    entry_t             mem [ENTRIES];
    entry_t             rd_raw_reg;
    logic               rd_valid_reg;
    logic [ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

// ===== rtl/mmt_calc.sv =====
// Mixing datapath: a multiply stage, a scaling and clamping stage, and a final sum.
// The final sum and the output mapping are combinational from the second stage.
// Depends on mmt_pkg.
module mmt_calc
    import mmt_pkg::*;
(
    input  logic        clk,
    input  calc_ctl_t   ctl,
    input  req_t        item,
    input  entry_t      ent,
    input  logic [15:0] note_voltage,
    output logic [15:0] level,
    output logic        changed
);

    function automatic logic [15:0] clamp16(input logic signed [22:0] x);
        logic [15:0] r;
        if (x < 0)
        begin
            r = 16'h0000;
        end
        else if (x > 23'sd65535)
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

    // Multiply stage.
    logic signed [16:0] nt_a, lfo_a, adsr_a, ad_a;
    logic signed [16:0] nt_b, lfo_b, adsr_b, ad_b;
    logic               lin_mode, inv_map, pitch_mode;
    logic [15:0]        lfo_shr;

    logic signed [33:0] p_nt_reg, p_lfo_reg, p_adsr_reg, p_ad_reg;
    logic [15:0]        base_reg, last_reg;
    logic               note_nz_reg, lin_reg, inv_reg, pitch_reg, force_reg;

    always_comb
    begin
        lin_mode   = (item.command == CMD_LINEAR) || (item.command == CMD_INVERT);
        pitch_mode = (item.command == CMD_PITCH);
        inv_map    = (item.command == CMD_INVERT) || (item.command == CMD_LOG);
        lfo_shr    = {2'b00, item.lfo_level[15:2]} + 16'h8000;

        nt_a = pitch_mode ? $signed({1'b0, note_voltage})
                          : $signed({1'b0, note_voltage}) - 17'sh2400;
        lfo_a = lin_mode ? $signed({1'b0, item.lfo_level}) - 17'sh8000
                         : $signed({1'b0, lfo_shr});
        adsr_a = $signed({1'b0, item.adsr_level});
        ad_a   = $signed({1'b0, item.ad_level});

        nt_b   = $signed({ent.note[15], ent.note});
        lfo_b  = $signed({ent.lfo_amt[15], ent.lfo_amt});
        adsr_b = $signed({ent.adsr_amt[15], ent.adsr_amt});
        ad_b   = $signed({ent.ad_amt[15], ent.ad_amt});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            p_nt_reg    <= nt_a * nt_b;
            p_lfo_reg   <= lfo_a * lfo_b;
            p_adsr_reg  <= adsr_a * adsr_b;
            p_ad_reg    <= ad_a * ad_b;
            base_reg    <= ent.base;
            last_reg    <= ent.last;
            note_nz_reg <= (ent.note != 16'h0000);
            lin_reg     <= lin_mode;
            inv_reg     <= inv_map;
            pitch_reg   <= pitch_mode;
            force_reg   <= (item.command == CMD_LOG) && item.force_update;
        end
    end

    // Scaling and clamping stage; every shift rounds toward minus infinity.
    logic signed [19:0] nt_s, lfo_s;
    logic signed [20:0] nt_r, env_s;
    logic [15:0]        nt_c, pn, pp;
    logic signed [22:0] pp_s;
    logic [16:0]        head;

    logic [16:0]        head_reg;
    logic signed [19:0] lfo_reg;
    logic signed [20:0] env_reg;
    logic [15:0]        last2_reg;
    logic               inv2_reg, force2_reg;

    always_comb
    begin
        nt_s = 20'(p_nt_reg >>> 14);
        nt_r = 21'(nt_s) + 21'sd9216;
        nt_c = clamp16(23'(nt_r));
        pn   = clamp16(23'(nt_s));
        pp_s = $signed({7'b0, pn}) + $signed({7'b0, base_reg}) - 23'sd32768;
        pp   = clamp16(pp_s);

        if (pitch_reg)
        begin
            head = {1'b0, pp};
        end
        else if (lin_reg)
        begin
            head = {1'b0, base_reg} + (note_nz_reg ? {1'b0, nt_c} : 17'd0);
        end
        else
        begin
            head = {1'b0, base_reg};
        end

        lfo_s = lin_reg ? 20'(p_lfo_reg >>> 15) : 20'(p_lfo_reg >>> 14);
        env_s = 21'(20'(p_adsr_reg >>> 14)) + 21'(20'(p_ad_reg >>> 14));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_en)
        begin
            head_reg   <= head;
            lfo_reg    <= lfo_s;
            env_reg    <= env_s;
            last2_reg  <= last_reg;
            inv2_reg   <= inv_reg;
            force2_reg <= force_reg;
        end
    end

    // Final sum and output mapping.
    logic signed [22:0] sum;

    always_comb
    begin
        sum = $signed({6'b0, head_reg}) + 23'(lfo_reg) + 23'(env_reg);
        if (!inv2_reg)
        begin
            level = clamp16(sum);
        end
        else if (sum < 0)
        begin
            level = 16'hFFFF;
        end
        else if (sum > 23'sd65535)
        begin
            level = 16'h0000;
        end
        else
        begin
            level = 16'hFFFF - sum[15:0];
        end
        changed = (level != last2_reg) || force2_reg;
    end

endmodule
